// ===== rtl/assert_macros.svh =====
// assertion macros shared by the tile decomposer rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GTD_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtd assertion failed");

// next-cycle implication
`define GTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtd assertion failed");

`endif

// ===== rtl/gtd_pkg.sv =====
// shared widths, register indexes, reset values and types of the tile decomposer
// no dependencies
package gtd_pkg;

    localparam int GRID_W    = 13;
    localparam int PARTS_W   = 11;
    localparam int INDEX_W   = 10;
    localparam int COORD_W   = 12;
    localparam int MASK_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int DIV_W     = GRID_W;
    localparam int MUL_A_W   = GRID_W + PARTS_W;
    localparam int MUL_B_W   = PARTS_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    localparam int MAX_GRID_DEF  = 4096;
    localparam int MAX_PARTS_DEF = 1024;

    localparam int RST_GRID_WIDTH  = 64;
    localparam int RST_GRID_HEIGHT = 64;
    localparam int RST_PART_COUNT  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT  = 2'd2;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic [PARTS_W-1:0] columns;
        logic [PARTS_W-1:0] rows;
        logic [COORD_W-1:0] first_col;
        logic [COORD_W-1:0] last_col;
        logic [COORD_W-1:0] first_row;
        logic [COORD_W-1:0] last_row;
        logic [MASK_W-1:0]  neighbour_mask;
        logic [GRID_W-1:0]  halo_width;
        logic [GRID_W-1:0]  halo_height;
        logic               bad_index;
    } gtd_result_t;

endpackage

// ===== rtl/gtd_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on gtd_pkg and assert_macros.svh
`include "assert_macros.svh"

module gtd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gtd_pkg::div_req_t req,
    output gtd_pkg::div_rsp_t rsp
);

    localparam int W     = gtd_pkg::DIV_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             active_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     quot_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dvs_reg;

    logic [W:0] shifted;
    logic [W:0] diff;
    logic       ge;

    assign shifted = {rem_reg, quot_reg[W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= active_reg && (cnt_reg == CNT_W'(1));
            if (req.start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(W);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
        end
        else if (active_reg)
        begin
            quot_reg <= {quot_reg[W-2:0], ge};
            rem_reg  <= ge ? diff[W-1:0] : shifted[W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

    `GTD_ASSERT(a_div_nonzero, req.start, req.divisor != '0)
    `GTD_ASSERT(a_div_no_restart, req.start, !active_reg)

endmodule

// ===== rtl/gtd_seq.sv =====
// sequencer: divisor walk for the split, then tile bounds, mask and halo sizes
// depends on gtd_pkg, gtd_div and assert_macros.svh
`include "assert_macros.svh"

module gtd_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gtd_pkg::INDEX_W-1:0]  part_index,
    input  logic [gtd_pkg::GRID_W-1:0]   w,
    input  logic [gtd_pkg::GRID_W-1:0]   h,
    input  logic [gtd_pkg::PARTS_W-1:0]  p,
    output logic                         busy,
    output logic                         done,
    output gtd_pkg::gtd_result_t         result
);

    localparam int GW = gtd_pkg::GRID_W;
    localparam int PW = gtd_pkg::PARTS_W;
    localparam int AW = gtd_pkg::MUL_A_W;
    localparam int BW = gtd_pkg::MUL_B_W;
    localparam int RW = gtd_pkg::PROD_W;
    localparam int DW = gtd_pkg::DIV_W;
    localparam int CW = gtd_pkg::COORD_W;
    localparam int IW = PW + 1;

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_SPLIT  = 20'h00002,
        S_M_INIT = 20'h00004,
        S_D_INIT = 20'h00008,
        S_LOOP   = 20'h00010,
        S_DIV_P  = 20'h00020,
        S_M_WN   = 20'h00040,
        S_M_HI   = 20'h00080,
        S_M_D    = 20'h00100,
        S_M_DBR  = 20'h00200,
        S_M_BDN  = 20'h00400,
        S_M_CMP  = 20'h00800,
        S_TILE   = 20'h01000,
        S_DIV_X  = 20'h02000,
        S_DIV_W  = 20'h04000,
        S_DIV_H  = 20'h08000,
        S_M_X    = 20'h10000,
        S_M_Y    = 20'h20000,
        S_Y_CAP  = 20'h40000,
        S_FINISH = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    logic [gtd_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [PW-1:0]  bc_reg, bc_next;
    logic [PW-1:0]  br_reg, br_next;
    logic [PW-1:0]  nr_reg, nr_next;
    logic [AW-1:0]  bd_reg, bd_next;
    logic [AW-1:0]  d_reg, d_next;
    logic [RW-1:0]  t_reg, t_next;
    logic [RW-1:0]  prod_reg, prod_next;
    logic [PW-1:0]  cx_reg, cx_next;
    logic [PW-1:0]  cy_reg, cy_next;
    logic [GW-1:0]  cw_reg, cw_next;
    logic [GW-1:0]  ch_reg, ch_next;
    logic           wr_nz_reg, wr_nz_next;
    logic           hr_nz_reg, hr_nz_next;
    logic [GW-1:0]  x0_reg, x0_next;
    logic [GW-1:0]  y0_reg, y0_next;
    logic           bad_reg, bad_next;
    gtd_pkg::gtd_result_t result_reg, result_next;

    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;

    gtd_pkg::div_req_t div_req;
    gtd_pkg::div_rsp_t div_rsp;

    logic          last_cx;
    logic          last_cy;
    logic [GW-1:0] sx;
    logic [GW-1:0] sy;
    logic [gtd_pkg::MASK_W-1:0] mask;

    gtd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // tile geometry from the captured quotients and products
    always_comb
    begin
        last_cx = cx_reg == (bc_reg - PW'(1));
        last_cy = cy_reg == (br_reg - PW'(1));
        sx      = (wr_nz_reg && last_cx) ? (w - x0_reg) : cw_reg;
        sy      = (hr_nz_reg && last_cy) ? (h - y0_reg) : ch_reg;
        mask[0] = cx_reg != '0;
        mask[1] = !last_cx;
        mask[2] = cy_reg != '0;
        mask[3] = !last_cy;
        mask[4] = mask[0] && mask[2];
        mask[5] = mask[1] && mask[2];
        mask[6] = mask[0] && mask[3];
        mask[7] = mask[1] && mask[3];
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        i_next      = i_reg;
        bc_next     = bc_reg;
        br_next     = br_reg;
        nr_next     = nr_reg;
        bd_next     = bd_reg;
        d_next      = d_reg;
        t_next      = t_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cw_next     = cw_reg;
        ch_next     = ch_reg;
        wr_nz_next  = wr_nz_reg;
        hr_nz_next  = hr_nz_reg;
        x0_next     = x0_reg;
        y0_next     = y0_reg;
        bad_next    = bad_reg;
        result_next = result_reg;
        mul_a       = '0;
        mul_b       = '0;
        div_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next   = part_index;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                bc_next = PW'(1);
                i_next  = IW'(2);
                if (p == '0 || h == '0)
                begin
                    br_next    = (p == '0) ? PW'(1) : p;
                    state_next = S_TILE;
                end
                else
                begin
                    br_next    = p;
                    state_next = S_M_INIT;
                end
            end
            S_M_INIT:
            begin
                mul_a      = AW'(w);
                mul_b      = p;
                state_next = S_D_INIT;
            end
            S_D_INIT:
            begin
                // distance of the one-column split
                bd_next    = (prod_reg[AW-1:0] > AW'(h)) ? (prod_reg[AW-1:0] - AW'(h))
                                                         : (AW'(h) - prod_reg[AW-1:0]);
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (i_reg > IW'(p))
                begin
                    state_next = S_TILE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DW'(p);
                    div_req.divisor  = DW'(i_reg);
                    state_next       = S_DIV_P;
                end
            end
            S_DIV_P:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.rem != '0)
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_LOOP;
                    end
                    else
                    begin
                        nr_next    = div_rsp.quot[PW-1:0];
                        state_next = S_M_WN;
                    end
                end
            end
            S_M_WN:
            begin
                mul_a      = AW'(w);
                mul_b      = nr_reg;
                state_next = S_M_HI;
            end
            S_M_HI:
            begin
                mul_a      = AW'(h);
                mul_b      = i_reg[PW-1:0];
                t_next     = prod_reg;
                state_next = S_M_D;
            end
            S_M_D:
            begin
                d_next     = (t_reg[AW-1:0] > prod_reg[AW-1:0])
                           ? (t_reg[AW-1:0] - prod_reg[AW-1:0])
                           : (prod_reg[AW-1:0] - t_reg[AW-1:0]);
                state_next = S_M_DBR;
            end
            S_M_DBR:
            begin
                mul_a      = d_reg;
                mul_b      = br_reg;
                state_next = S_M_BDN;
            end
            S_M_BDN:
            begin
                mul_a      = bd_reg;
                mul_b      = nr_reg;
                t_next     = prod_reg;
                state_next = S_M_CMP;
            end
            S_M_CMP:
            begin
                // strict improvement keeps walking, a tie or worse ends the walk
                if (t_reg < prod_reg)
                begin
                    bd_next    = d_reg;
                    bc_next    = i_reg[PW-1:0];
                    br_next    = nr_reg;
                    i_next     = i_reg + IW'(1);
                    state_next = S_LOOP;
                end
                else
                begin
                    state_next = S_TILE;
                end
            end
            S_TILE:
            begin
                if (PW'(idx_reg) >= p)
                begin
                    bad_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    bad_next         = 1'b0;
                    div_req.start    = 1'b1;
                    div_req.dividend = DW'(idx_reg);
                    div_req.divisor  = DW'(bc_reg);
                    state_next       = S_DIV_X;
                end
            end
            S_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    cx_next          = div_rsp.rem[PW-1:0];
                    cy_next          = div_rsp.quot[PW-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = w;
                    div_req.divisor  = DW'(bc_reg);
                    state_next       = S_DIV_W;
                end
            end
            S_DIV_W:
            begin
                if (div_rsp.done)
                begin
                    cw_next          = div_rsp.quot;
                    wr_nz_next       = div_rsp.rem != '0;
                    div_req.start    = 1'b1;
                    div_req.dividend = h;
                    div_req.divisor  = DW'(br_reg);
                    state_next       = S_DIV_H;
                end
            end
            S_DIV_H:
            begin
                if (div_rsp.done)
                begin
                    ch_next    = div_rsp.quot;
                    hr_nz_next = div_rsp.rem != '0;
                    state_next = S_M_X;
                end
            end
            S_M_X:
            begin
                mul_a      = AW'(cw_reg);
                mul_b      = cx_reg;
                state_next = S_M_Y;
            end
            S_M_Y:
            begin
                mul_a      = AW'(ch_reg);
                mul_b      = cy_reg;
                x0_next    = prod_reg[GW-1:0];
                state_next = S_Y_CAP;
            end
            S_Y_CAP:
            begin
                y0_next    = prod_reg[GW-1:0];
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                result_next.columns   = bc_reg;
                result_next.rows      = br_reg;
                result_next.bad_index = bad_reg;
                if (bad_reg)
                begin
                    result_next.first_col      = '0;
                    result_next.last_col       = '0;
                    result_next.first_row      = '0;
                    result_next.last_row       = '0;
                    result_next.neighbour_mask = '0;
                    result_next.halo_width     = '0;
                    result_next.halo_height    = '0;
                end
                else
                begin
                    result_next.first_col      = x0_reg[CW-1:0];
                    result_next.last_col       = CW'(x0_reg + sx - GW'(1));
                    result_next.first_row      = y0_reg[CW-1:0];
                    result_next.last_row       = CW'(y0_reg + sy - GW'(1));
                    result_next.neighbour_mask = mask;
                    result_next.halo_width     = sx + GW'(mask[0]) + GW'(mask[1]);
                    result_next.halo_height    = sy + GW'(mask[2]) + GW'(mask[3]);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // one shared multiplier, product registered
    assign prod_next = RW'(mul_a) * RW'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        i_reg      <= i_next;
        bc_reg     <= bc_next;
        br_reg     <= br_next;
        nr_reg     <= nr_next;
        bd_reg     <= bd_next;
        d_reg      <= d_next;
        t_reg      <= t_next;
        prod_reg   <= prod_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cw_reg     <= cw_next;
        ch_reg     <= ch_next;
        wr_nz_reg  <= wr_nz_next;
        hr_nz_reg  <= hr_nz_next;
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        bad_reg    <= bad_next;
        result_reg <= result_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    `GTD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `GTD_ASSERT_NEXT(a_done_single, done, !done)

endmodule

// ===== rtl/grid_tile_decomposer.sv =====
// top level: configuration registers with saturation, sequencer and result ports
// depends on gtd_pkg and gtd_seq
//
//  channel   handshake           payload
//  config    cfg_write           cfg_index, cfg_data
//  request   start, busy         part_index
//  result    done (strobe)       columns .. bad_index
//
// a request is taken when start is high and busy is low; busy stays high until
// the result strobe; the divisor walk runs through one shared divider, one division
// per candidate divisor, plus three divisions and two products for the tile
// reset is asynchronous and loads 64 x 64 points, one part
// the result is shown for one cycle with done and cannot be held off

module grid_tile_decomposer #(
    parameter int MAX_GRID  = gtd_pkg::MAX_GRID_DEF,
    parameter int MAX_PARTS = gtd_pkg::MAX_PARTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [gtd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtd_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic                           start,
    input  logic [gtd_pkg::INDEX_W-1:0]    part_index,
    output logic                           busy,
    output logic                           done,
    output logic [gtd_pkg::PARTS_W-1:0]    columns,
    output logic [gtd_pkg::PARTS_W-1:0]    rows,
    output logic [gtd_pkg::COORD_W-1:0]    first_col,
    output logic [gtd_pkg::COORD_W-1:0]    last_col,
    output logic [gtd_pkg::COORD_W-1:0]    first_row,
    output logic [gtd_pkg::COORD_W-1:0]    last_row,
    output logic [gtd_pkg::MASK_W-1:0]     neighbour_mask,
    output logic [gtd_pkg::GRID_W-1:0]     halo_width,
    output logic [gtd_pkg::GRID_W-1:0]     halo_height,
    output logic                           bad_index
);

    localparam int GW = gtd_pkg::GRID_W;
    localparam int PW = gtd_pkg::PARTS_W;

    logic [GW-1:0] grid_width_reg;
    logic [GW-1:0] grid_height_reg;
    logic [PW-1:0] part_count_reg;

    logic [GW-1:0] w_sat;
    logic [GW-1:0] h_sat;
    logic [PW-1:0] p_sat;

    gtd_pkg::gtd_result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GW'(gtd_pkg::RST_GRID_WIDTH);
            grid_height_reg <= GW'(gtd_pkg::RST_GRID_HEIGHT);
            part_count_reg  <= PW'(gtd_pkg::RST_PART_COUNT);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gtd_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GW-1:0];
                gtd_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[GW-1:0];
                gtd_pkg::CFG_PART_COUNT:  part_count_reg  <= cfg_data[PW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp to the supported grid and part limits
    assign w_sat = (int'(grid_width_reg) > MAX_GRID) ? GW'(MAX_GRID) : grid_width_reg;
    assign h_sat = (int'(grid_height_reg) > MAX_GRID) ? GW'(MAX_GRID) : grid_height_reg;
    assign p_sat = (int'(part_count_reg) > MAX_PARTS) ? PW'(MAX_PARTS) : part_count_reg;

    gtd_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .part_index (part_index),
        .w          (w_sat),
        .h          (h_sat),
        .p          (p_sat),
        .busy       (busy),
        .done       (done),
        .result     (result)
    );

    assign columns        = result.columns;
    assign rows           = result.rows;
    assign first_col      = result.first_col;
    assign last_col       = result.last_col;
    assign first_row      = result.first_row;
    assign last_row       = result.last_row;
    assign neighbour_mask = result.neighbour_mask;
    assign halo_width     = result.halo_width;
    assign halo_height    = result.halo_height;
    assign bad_index      = result.bad_index;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench of grid_tile_decomposer: directed table, then random config phases
// tiles are predicted in-bench from the register copies; depends on gtd_pkg and the rtl
module tb_top;

    import gtd_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 100;
    localparam int IDLE_PCT     = 14;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int MAX_GRID     = MAX_GRID_DEF;
    localparam int MAX_PARTS    = MAX_PARTS_DEF;

    // neighbour mask bit positions
    localparam int NB_XM   = 0;
    localparam int NB_XP   = 1;
    localparam int NB_YM   = 2;
    localparam int NB_YP   = 3;
    localparam int NB_XMYM = 4;
    localparam int NB_XPYM = 5;
    localparam int NB_XMYP = 6;
    localparam int NB_XPYP = 7;

    typedef enum bit {DO_WRITE, DO_QUERY} step_kind_e;

    typedef struct {
        step_kind_e           kind;
        logic [CFG_IDX_W-1:0] sel;
        logic [CFG_DAT_W-1:0] value;
        bit                   typed;
        gtd_result_t          want;
    } step_t;

    localparam gtd_result_t WHOLE_64 = '{columns: 11'd1, rows: 11'd1,
        first_col: 12'd0, last_col: 12'd63, first_row: 12'd0, last_row: 12'd63,
        neighbour_mask: 8'd0, halo_width: 13'd64, halo_height: 13'd64, bad_index: 1'b0};
    localparam gtd_result_t CORNER_2X2 = '{columns: 11'd2, rows: 11'd2,
        first_col: 12'd32, last_col: 12'd63, first_row: 12'd32, last_row: 12'd63,
        neighbour_mask: 8'd21, halo_width: 13'd33, halo_height: 13'd33, bad_index: 1'b0};
    localparam gtd_result_t BAD_1X1 = '{columns: 11'd1, rows: 11'd1, bad_index: 1'b1,
        default: '0};
    localparam gtd_result_t BAD_2X2 = '{columns: 11'd2, rows: 11'd2, bad_index: 1'b1,
        default: '0};

    localparam int PLAN_LEN = 39;

    step_t plan [PLAN_LEN] = '{
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd0,    1'b1, WHOLE_64},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd1,    1'b1, BAD_1X1},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd1023, 1'b1, BAD_1X1},
        '{DO_WRITE, CFG_PART_COUNT,  13'd4,    1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd3,    1'b1, CORNER_2X2},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd0,    1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd4,    1'b1, BAD_2X2},
        // zero width: empty tiles along x
        '{DO_WRITE, CFG_GRID_WIDTH,  13'd0,    1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd0,    1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd3,    1'b0, '0},
        // zero height: one column, empty tiles along y
        '{DO_WRITE, CFG_GRID_WIDTH,  13'd100,  1'b0, '0},
        '{DO_WRITE, CFG_GRID_HEIGHT, 13'd0,    1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd2,    1'b0, '0},
        // zero parts: everything is out of range
        '{DO_WRITE, CFG_PART_COUNT,  13'd0,    1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd0,    1'b1, BAD_1X1},
        // 5 x 8 into 4 parts: a tie at the second divisor stops the walk
        '{DO_WRITE, CFG_GRID_WIDTH,  13'd5,    1'b0, '0},
        '{DO_WRITE, CFG_GRID_HEIGHT, 13'd8,    1'b0, '0},
        '{DO_WRITE, CFG_PART_COUNT,  13'd4,    1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd0,    1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd3,    1'b0, '0},
        // remainders on both axes
        '{DO_WRITE, CFG_GRID_WIDTH,  13'd10,   1'b0, '0},
        '{DO_WRITE, CFG_GRID_HEIGHT, 13'd7,    1'b0, '0},
        '{DO_WRITE, CFG_PART_COUNT,  13'd6,    1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd5,    1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd0,    1'b0, '0},
        // oversized registers saturate
        '{DO_WRITE, CFG_GRID_WIDTH,  13'd8191, 1'b0, '0},
        '{DO_WRITE, CFG_GRID_HEIGHT, 13'd1,    1'b0, '0},
        '{DO_WRITE, CFG_PART_COUNT,  13'd8191, 1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd1023, 1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd512,  1'b0, '0},
        '{DO_WRITE, CFG_GRID_WIDTH,  13'd4096, 1'b0, '0},
        '{DO_WRITE, CFG_GRID_HEIGHT, 13'd4096, 1'b0, '0},
        '{DO_WRITE, CFG_PART_COUNT,  13'd1024, 1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd1023, 1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd0,    1'b0, '0},
        '{DO_WRITE, CFG_GRID_WIDTH,  13'd1,    1'b0, '0},
        '{DO_WRITE, CFG_GRID_HEIGHT, 13'd8191, 1'b0, '0},
        '{DO_WRITE, CFG_PART_COUNT,  13'd2,    1'b0, '0},
        '{DO_QUERY, CFG_GRID_WIDTH,  13'd1,    1'b0, '0}
    };

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DAT_W-1:0]  cfg_data   = '0;
    logic                  start      = 1'b0;
    logic [INDEX_W-1:0]    part_index = '0;
    logic                  busy;
    logic                  done;
    logic [PARTS_W-1:0]    columns;
    logic [PARTS_W-1:0]    rows;
    logic [COORD_W-1:0]    first_col;
    logic [COORD_W-1:0]    last_col;
    logic [COORD_W-1:0]    first_row;
    logic [COORD_W-1:0]    last_row;
    logic [MASK_W-1:0]     neighbour_mask;
    logic [GRID_W-1:0]     halo_width;
    logic [GRID_W-1:0]     halo_height;
    logic                  bad_index;

    // register copies
    logic [GRID_W-1:0]     reg_width  = GRID_W'(RST_GRID_WIDTH);
    logic [GRID_W-1:0]     reg_height = GRID_W'(RST_GRID_HEIGHT);
    logic [PARTS_W-1:0]    reg_parts  = PARTS_W'(RST_PART_COUNT);

    gtd_result_t tiles_due [$];
    int          mismatches   = 0;
    int          queries_sent = 0;
    int          bad_sent     = 0;
    int          writes_done  = 0;
    int          phases       = 0;
    int unsigned cycles       = 0;
    bit          steady       = 1'b0;

    grid_tile_decomposer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .part_index     (part_index),
        .busy           (busy),
        .done           (done),
        .columns        (columns),
        .rows           (rows),
        .first_col      (first_col),
        .last_col       (last_col),
        .first_row      (first_row),
        .last_row       (last_row),
        .neighbour_mask (neighbour_mask),
        .halo_width     (halo_width),
        .halo_height    (halo_height),
        .bad_index      (bad_index)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned parts_in_use();
        return (reg_parts > MAX_PARTS) ? MAX_PARTS : reg_parts;
    endfunction

    // split search and tile placement for the current registers
    function automatic gtd_result_t tile_of(input logic [INDEX_W-1:0] idx);
        gtd_result_t       r;
        int unsigned       w, h, p, bc, br, nr, cx, cy, cw, ch, x0, y0, sx, sy;
        longint unsigned   a, b, bd, d;
        logic [MASK_W-1:0] m;
        w = (reg_width > MAX_GRID) ? MAX_GRID : reg_width;
        h = (reg_height > MAX_GRID) ? MAX_GRID : reg_height;
        p = parts_in_use();
        bc = 1;
        br = (p == 0) ? 1 : p;
        if (p != 0 && h != 0) begin
            a = longint'(w) * br;
            b = longint'(h) * bc;
            bd = (a > b) ? a - b : b - a;
            for (int unsigned i = 2; i <= p; i++) begin
                if (p % i == 0) begin
                    nr = p / i;
                    a = longint'(w) * nr;
                    b = longint'(h) * i;
                    d = (a > b) ? a - b : b - a;
                    if (d * br < bd * nr) begin
                        bd = d;
                        bc = i;
                        br = nr;
                    end
                    else
                    begin
                        break;
                    end
                end
            end
        end
        r = '0;
        r.columns = PARTS_W'(bc);
        r.rows = PARTS_W'(br);
        if (idx >= p) begin
            r.bad_index = 1'b1;
            return r;
        end
        cx = idx % bc;
        cy = idx / bc;
        cw = w / bc;
        ch = h / br;
        x0 = cx * cw;
        y0 = cy * ch;
        sx = cw;
        sy = ch;
        if (w % bc != 0 && cx == bc - 1)
            sx = w - x0;
        if (h % br != 0 && cy == br - 1)
            sy = h - y0;
        m = '0;
        m[NB_XM] = (cx != 0);
        m[NB_XP] = (cx != bc - 1);
        m[NB_YM] = (cy != 0);
        m[NB_YP] = (cy != br - 1);
        m[NB_XMYM] = m[NB_XM] & m[NB_YM];
        m[NB_XPYM] = m[NB_XP] & m[NB_YM];
        m[NB_XMYP] = m[NB_XM] & m[NB_YP];
        m[NB_XPYP] = m[NB_XP] & m[NB_YP];
        r.first_col = COORD_W'(x0);
        r.last_col = COORD_W'(x0 + sx - 1);
        r.first_row = COORD_W'(y0);
        r.last_row = COORD_W'(y0 + sy - 1);
        r.neighbour_mask = m;
        r.halo_width = GRID_W'(sx + m[NB_XM] + m[NB_XP]);
        r.halo_height = GRID_W'(sy + m[NB_YM] + m[NB_YP]);
        return r;
    endfunction

    // called at a rising edge; returns at the edge that takes the request
    task automatic issue_request(input logic [INDEX_W-1:0] idx, input bit typed,
                                 input gtd_result_t want);
        bit taken;
        taken = 1'b0;
        part_index <= idx;
        while (!taken) begin
            if (!steady && $urandom_range(0, 99) < IDLE_PCT)
                start <= 1'b0;
            else
                start <= 1'b1;
            @(posedge clk);
            taken = start && !busy;
        end
        if (!typed)
            want = tile_of(idx);
        tiles_due.push_back(want);
        queries_sent++;
        if (want.bad_index)
            bad_sent++;
    endtask

    // hold off until every requested tile has come back
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (tiles_due.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] sel,
                                  input logic [CFG_DAT_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (sel)
            CFG_GRID_WIDTH:  reg_width = value;
            CFG_GRID_HEIGHT: reg_height = value;
            CFG_PART_COUNT:  reg_parts = value[PARTS_W-1:0];
            default: ;
        endcase
        writes_done++;
        @(posedge clk);
    endtask

    function automatic logic [CFG_DAT_W-1:0] pick_extent();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DAT_W'($urandom_range(MAX_GRID + 1, 8191));
            2: return CFG_DAT_W'(MAX_GRID);
            3: return CFG_DAT_W'(1);
            default: return CFG_DAT_W'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] pick_parts();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return CFG_DAT_W'($urandom_range(MAX_PARTS + 1, 8191));
            2: return CFG_DAT_W'(MAX_PARTS);
            3: return CFG_DAT_W'($urandom_range(129, MAX_PARTS - 1));
            4: return CFG_DAT_W'(1);
            default: return CFG_DAT_W'($urandom_range(2, 64));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    // results are taken at the edge that ends the strobe cycle
    always @(posedge clk) begin
        gtd_result_t want;
        if (rst_n && done) begin
            if (tiles_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result with no pending request", $realtime);
            end
            else
            begin
                want = tiles_due.pop_front();
                check_field("columns", columns, want.columns);
                check_field("rows", rows, want.rows);
                check_field("first_col", first_col, want.first_col);
                check_field("last_col", last_col, want.last_col);
                check_field("first_row", first_row, want.first_row);
                check_field("last_row", last_row, want.last_row);
                check_field("neighbour_mask", neighbour_mask, want.neighbour_mask);
                check_field("halo_width", halo_width, want.halo_width);
                check_field("halo_height", halo_height, want.halo_height);
                check_field("bad_index", bad_index, want.bad_index);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timed out after %0d cycles with %0d requests pending", cycles,
                 tiles_due.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int                   sent;
        int                   burst;
        int unsigned          p;
        logic [INDEX_W-1:0]   idx;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        foreach (plan[n]) begin
            if (plan[n].kind == DO_WRITE) begin
                wait_idle();
                write_register(plan[n].sel, plan[n].value);
            end
            else
            begin
                issue_request(plan[n].value[INDEX_W-1:0], plan[n].typed, plan[n].want);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            phases++;
            write_register(CFG_GRID_WIDTH, pick_extent());
            write_register(CFG_GRID_HEIGHT, pick_extent());
            write_register(CFG_PART_COUNT, pick_parts());
            p = parts_in_use();
            // long divisor walks for big part counts, so keep those phases short
            burst = (p > 128) ? 2 : $urandom_range(4, 12);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                steady = (sent >= 40 && sent < 70);
                if (p != 0 && $urandom_range(0, 99) < 80)
                    idx = INDEX_W'($urandom_range(0, p - 1));
                else
                    idx = INDEX_W'($urandom_range(0, 1023));
                issue_request(idx, 1'b0, '0);
                sent++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d tile requests (%0d out of range), %0d register writes, %0d random phases",
                 queries_sent, bad_sent, writes_done, phases);
        if (mismatches == 0 && tiles_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gtd_pkg.sv
rtl/gtd_div.sv
rtl/gtd_seq.sv
rtl/grid_tile_decomposer.sv
tb/tb_top.sv
